>>> hdl/smf_pkg.sv
package smf_pkg;

    localparam int WINDOW_DEF = 5;
    localparam int WHOLE_W    = 8;
    localparam int TENTH_W    = 8;
    localparam int SAMPLE_W   = 12;

    typedef logic [SAMPLE_W-1:0] sample_t;
    typedef logic [WHOLE_W-1:0]  whole_t;
    typedef logic [TENTH_W-1:0]  tenth_t;

    localparam logic STATUS_VALID   = 1'b0;
    localparam logic STATUS_NO_DATA = 1'b1;

    // whole*10 + tenth as two shifts and adds; max 2805 fits in 12 bits
    function automatic sample_t to_tenths(input whole_t whole, input tenth_t tenth);
        sample_t w;
        begin
            w = sample_t'(whole);
            to_tenths = (w << 3) + (w << 1) + sample_t'(tenth);
        end
    endfunction

endpackage

>>> hdl/smf_if.sv
interface smf_in_if;
    import smf_pkg::*;

    logic   valid;
    logic   ready;
    whole_t whole_degrees;
    tenth_t tenth_degrees;
    logic   read_ok;

    modport source (output valid, output whole_degrees, output tenth_degrees,
                    output read_ok, input ready);
    modport sink   (input valid, input whole_degrees, input tenth_degrees,
                    input read_ok, output ready);
endinterface

interface smf_out_if;
    import smf_pkg::*;

    logic    valid;
    logic    ready;
    sample_t median_tenths;
    logic    status;

    modport source (output valid, output median_tenths, output status, input ready);
    modport sink   (input valid, input median_tenths, input status, output ready);
endinterface

>>> hdl/smf_cell.sv
module smf_cell #(
    parameter int WINDOW = smf_pkg::WINDOW_DEF,
    parameter int INDEX  = 0,
    parameter int CW     = $clog2(WINDOW + 1)
) (
    input  logic                                clk,
    input  logic                                shift,
    input  smf_pkg::sample_t                    shift_in,
    input  logic [CW-1:0]                       fill_count,
    input  smf_pkg::sample_t [WINDOW-1:0]       samples,
    output smf_pkg::sample_t                    sample,
    output logic [CW-1:0]                       rank
);
    import smf_pkg::*;

    sample_t       sample_reg;
    logic [CW-1:0] rank_reg;
    logic [CW-1:0] rank_next;
    logic [WINDOW-1:0] below;

    // a held sample ranks below this one if smaller, or equal and younger
    always_comb
    begin
        for (int j = 0; j < WINDOW; j++)
        begin
            below[j] = (j != INDEX) && (CW'(j) < fill_count) &&
                       ((samples[j] < sample_reg) ||
                        ((samples[j] == sample_reg) && (j < INDEX)));
        end
        rank_next = '0;
        for (int j = 0; j < WINDOW; j++)
        begin
            rank_next = rank_next + CW'(below[j]);
        end
    end

    always_ff @(posedge clk)
    begin
        if (shift)
        begin
            sample_reg <= shift_in;
        end
        rank_reg <= rank_next;
    end

    assign sample = sample_reg;
    assign rank   = rank_reg;

endmodule

>>> hdl/sliding_median_filter_unit.sv
// Sliding-window median over the last WINDOW good readings.
// Each reading passes IDLE (shift into the cell chain), RANK (register every
// cell's rank) and EMIT (pick the cell whose rank is count/2), which waits while
// an earlier result is unaccepted; a new reading is taken only in IDLE.
// Reset clears the fill count and all handshake state; the window starts empty.
module sliding_median_filter_unit #(
    parameter int WINDOW = smf_pkg::WINDOW_DEF
) (
    input  logic             clk,
    input  logic             rst_n,
    smf_in_if.sink           reading,
    smf_out_if.source        result
);
    import smf_pkg::*;

    localparam int CW = $clog2(WINDOW + 1);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_RANK = 2'd1;
    localparam logic [1:0] ST_EMIT = 2'd2;

    logic [1:0]    state_reg;
    logic [1:0]    state_next;
    logic [CW-1:0] fill_count_reg;
    logic [CW-1:0] fill_count_next;
    logic          out_valid_reg;
    logic          out_valid_next;
    sample_t       median_reg;
    logic          status_reg;

    logic          accept;
    logic          shift;
    logic          load_out;
    sample_t       new_value;
    sample_t       median_sel;
    logic [CW-1:0] target;

    sample_t [WINDOW-1:0] chain;
    sample_t [WINDOW-1:0] shift_in_w;
    logic [CW-1:0]        rank_w [WINDOW];

    assign reading.ready = (state_reg == ST_IDLE);
    assign accept        = reading.valid && reading.ready;
    assign shift         = accept && reading.read_ok;
    assign new_value     = to_tenths(reading.whole_degrees, reading.tenth_degrees);

    // newest word enters cell 0, oldest falls off the end
    for (genvar g = 0; g < WINDOW; g++)
    begin : g_cell
        if (g == 0)
        begin : g_head
            assign shift_in_w[g] = new_value;
        end
        else
        begin : g_link
            assign shift_in_w[g] = chain[g-1];
        end

        smf_cell #(
            .WINDOW (WINDOW),
            .INDEX  (g),
            .CW     (CW)
        ) u_cell (
            .clk        (clk),
            .shift      (shift),
            .shift_in   (shift_in_w[g]),
            .fill_count (fill_count_reg),
            .samples    (chain),
            .sample     (chain[g]),
            .rank       (rank_w[g])
        );
    end

    assign target = fill_count_reg >> 1;

    always_comb
    begin
        median_sel = '0;
        for (int i = 0; i < WINDOW; i++)
        begin
            if ((CW'(i) < fill_count_reg) && (rank_w[i] == target))
            begin
                median_sel = median_sel | chain[i];
            end
        end
    end

    always_comb
    begin
        state_next      = state_reg;
        fill_count_next = fill_count_reg;
        out_valid_next  = out_valid_reg;
        load_out        = 1'b0;

        if (out_valid_reg && result.ready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    state_next = ST_RANK;
                    if (reading.read_ok && (fill_count_reg != CW'(WINDOW)))
                    begin
                        fill_count_next = fill_count_reg + CW'(1);
                    end
                end
            end
            ST_RANK:
            begin
                state_next = ST_EMIT;
            end
            ST_EMIT:
            begin
                if (!out_valid_reg || result.ready)
                begin
                    load_out       = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            fill_count_reg <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            fill_count_reg <= fill_count_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load_out)
        begin
            median_reg <= median_sel;
            status_reg <= (fill_count_reg == '0) ? STATUS_NO_DATA : STATUS_VALID;
        end
    end

    assign result.valid         = out_valid_reg;
    assign result.median_tenths = median_reg;
    assign result.status        = status_reg;

endmodule
